@@ src/fuw_pkg.sv @@
// Package for the frame update word writer: shared constants, codes and the
// item and result structs. Depends on nothing.
package fuw_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int ROWS_DEF            = 480;
    localparam int ROW_WORDS_DEF       = 160;
    localparam int HALF_ROWS_DEF       = 240;
    localparam int HALF_ROW_WORDS_DEF  = 80;
    localparam int HALF_LEFT_BYTES_DEF = 160;
    localparam int HALF_TOP_ROWS_DEF   = 120;

    // Fixed widths, sized for the whole legal range of the geometry
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 17;
    localparam int MODE_W   = 2;
    localparam int FMT_W    = 3;
    localparam int CALC_W   = 22;   // internal address arithmetic
    localparam int ROW_CNT_W = 11;  // row counter, holds up to 2047
    localparam int COL_W    = 8;    // column counter, below HALF_ROW_WORDS
    localparam int BIT_W    = 5;    // chunk index within a row
    localparam int WORD_W   = 3;    // word within a chunk
    localparam int CHUNKS   = 32;
    localparam int CHUNK_WORDS = 5;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Frame format codes
    localparam logic [FMT_W-1:0] FMT_COPY_LAST  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_FULL_RAW   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_HALF_RAW   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_FULL_DELTA = 3'd3;
    localparam logic [FMT_W-1:0] FMT_HALF_DELTA = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } result_t;

endpackage

@@ src/frame_update_word_writer.sv @@
// Frame update word writer: image words in, framebuffer word writes out.
// Each item is registered in the input stage, then its result in the output register.
// Throughput: one item per cycle while the sink takes results; each item is one pass through the counters.
// A result held in the output register blocks a new item only while the sink stalls.
// Reset: frame format 0 (copy last), all positions zero, mask expected first.
// Depends on fuw_pkg, fuw_in_stage, fuw_core and fuw_out_stage.
module frame_update_word_writer
#(
    parameter int ROWS            = fuw_pkg::ROWS_DEF,
    parameter int ROW_WORDS       = fuw_pkg::ROW_WORDS_DEF,
    parameter int HALF_ROWS       = fuw_pkg::HALF_ROWS_DEF,
    parameter int HALF_ROW_WORDS  = fuw_pkg::HALF_ROW_WORDS_DEF,
    parameter int HALF_LEFT_BYTES = fuw_pkg::HALF_LEFT_BYTES_DEF,
    parameter int HALF_TOP_ROWS   = fuw_pkg::HALF_TOP_ROWS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Frame format register write
    input  logic                         frame_format_write,
    input  logic [fuw_pkg::FMT_W-1:0]    frame_format,
    // Image word items
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fuw_pkg::MODE_W-1:0]   mode,
    input  logic [fuw_pkg::DATA_W-1:0]   data,
    // Framebuffer write items
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fuw_pkg::ADDR_W-1:0]   word_address,
    output logic [fuw_pkg::DATA_W-1:0]   word_data
);

    fuw_pkg::item_t   in_item;
    fuw_pkg::item_t   stage_item;
    fuw_pkg::result_t core_res;
    fuw_pkg::result_t out_res;
    logic             stage_valid;
    logic             core_valid;
    logic             out_space;
    logic             advance;

    assign in_item.mode = mode;
    assign in_item.data = data;

    // Advance the held item into the counters when the result register is free;
    // items that write nothing still advance so the counters move
    assign advance = stage_valid && out_space;

    fuw_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    fuw_core
    #(
        .ROWS            (ROWS),
        .ROW_WORDS       (ROW_WORDS),
        .HALF_ROWS       (HALF_ROWS),
        .HALF_ROW_WORDS  (HALF_ROW_WORDS),
        .HALF_LEFT_BYTES (HALF_LEFT_BYTES),
        .HALF_TOP_ROWS   (HALF_TOP_ROWS)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (frame_format_write),
        .cfg_data   (frame_format),
        .item_valid (stage_valid),
        .item       (stage_item),
        .advance    (advance),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    // Hold the result here so a new item can enter while it waits
    fuw_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (core_valid),
        .res       (core_res),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign word_address = out_res.address;
    assign word_data    = out_res.data;

endmodule

@@ src/fuw_in_stage.sv @@
// Input register of the frame update word writer.
// Depends on fuw_pkg for the item struct.
module fuw_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fuw_pkg::item_t in_item,
    input  logic           advance,
    output logic           stage_valid,
    output fuw_pkg::item_t stage_item
);

    logic           valid_reg;
    logic           valid_next;
    fuw_pkg::item_t item_reg;

    // Take a new item when empty or whenever the held one leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

@@ src/fuw_core.sv @@
// Position counters, format register and address generation of the frame
// update word writer. Depends on fuw_pkg for widths, codes and structs.
module fuw_core
#(
    parameter int ROWS            = fuw_pkg::ROWS_DEF,
    parameter int ROW_WORDS       = fuw_pkg::ROW_WORDS_DEF,
    parameter int HALF_ROWS       = fuw_pkg::HALF_ROWS_DEF,
    parameter int HALF_ROW_WORDS  = fuw_pkg::HALF_ROW_WORDS_DEF,
    parameter int HALF_LEFT_BYTES = fuw_pkg::HALF_LEFT_BYTES_DEF,
    parameter int HALF_TOP_ROWS   = fuw_pkg::HALF_TOP_ROWS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [fuw_pkg::FMT_W-1:0]   cfg_data,
    input  logic                        item_valid,
    input  fuw_pkg::item_t              item,
    input  logic                        advance,
    output logic                        res_valid,
    output fuw_pkg::result_t            res
);

    localparam int CW = fuw_pkg::CALC_W;
    localparam int RW = fuw_pkg::ROW_CNT_W;
    localparam int LW = fuw_pkg::COL_W;
    localparam int BW = fuw_pkg::BIT_W;
    localparam int WW = fuw_pkg::WORD_W;
    localparam int DW = fuw_pkg::DATA_W;

    localparam logic [CW-1:0] TOTAL     = CW'(ROWS * ROW_WORDS);
    localparam logic [CW-1:0] HALF_BASE = CW'(HALF_LEFT_BYTES / 4 + HALF_TOP_ROWS * ROW_WORDS);
    localparam logic [CW-1:0] PITCH     = CW'(ROW_WORDS);
    localparam logic [RW-1:0] ROW_LIM   = RW'(ROWS);
    localparam logic [RW-1:0] HALF_LIM  = RW'(HALF_ROWS);
    localparam logic [LW-1:0] COL_LIM   = LW'(HALF_ROW_WORDS);
    localparam logic [WW-1:0] LAST_WORD = WW'(fuw_pkg::CHUNK_WORDS - 1);

    logic [fuw_pkg::FMT_W-1:0] format_reg;
    logic [CW-1:0] write_ptr_reg, write_ptr_next;
    logic [CW-1:0] clear_ptr_reg, clear_ptr_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] row_base_reg, row_base_next;   // row_cnt_reg * ROW_WORDS
    logic [LW-1:0] col_cnt_reg, col_cnt_next;
    logic [DW-1:0] row_mask_reg, row_mask_next;
    logic [BW-1:0] chunk_bit_reg, chunk_bit_next;
    logic [WW-1:0] chunk_word_reg, chunk_word_next;
    logic          awaiting_reg, awaiting_next;

    // Next set mask bit at or above the start point
    logic [DW-1:0] seek_mask;
    logic [BW:0]   seek_start;
    logic [DW-1:0] seek_left;
    logic [BW-1:0] seek_idx;
    logic          seek_found;

    logic [CW-1:0] half_addr;
    logic [CW-1:0] delta_addr;
    logic [CW-1:0] chunk_off;
    logic [LW-1:0] col_inc;
    logic [CW-1:0] emit_addr;

    assign seek_mask  = awaiting_reg ? item.data : row_mask_reg;
    assign seek_start = awaiting_reg ? '0 : ({1'b0, chunk_bit_reg} + (BW+1)'(1));
    assign seek_left  = seek_mask & ({DW{1'b1}} << seek_start);
    assign seek_found = |seek_left;

    always_comb
    begin
        seek_idx = '0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            if (seek_left[i])
            begin
                seek_idx = BW'(i);
            end
        end
    end

    assign chunk_off  = CW'({chunk_bit_reg, 2'b00}) + CW'(chunk_bit_reg);
    assign delta_addr = row_base_reg + chunk_off + CW'(chunk_word_reg);
    assign half_addr  = HALF_BASE + row_base_reg + CW'(col_cnt_reg);
    assign col_inc    = col_cnt_reg + LW'(1);

    always_comb
    begin
        write_ptr_next  = write_ptr_reg;
        clear_ptr_next  = clear_ptr_reg;
        row_cnt_next    = row_cnt_reg;
        row_base_next   = row_base_reg;
        col_cnt_next    = col_cnt_reg;
        row_mask_next   = row_mask_reg;
        chunk_bit_next  = chunk_bit_reg;
        chunk_word_next = chunk_word_reg;
        awaiting_next   = awaiting_reg;
        res_valid       = 1'b0;
        emit_addr       = '0;
        res.data        = item.data;

        if (item_valid)
        begin
            case (item.mode)
                fuw_pkg::MODE_BEGIN:
                begin
                    write_ptr_next  = '0;
                    clear_ptr_next  = '0;
                    row_cnt_next    = '0;
                    row_base_next   = '0;
                    col_cnt_next    = '0;
                    row_mask_next   = '0;
                    chunk_bit_next  = '0;
                    chunk_word_next = '0;
                    awaiting_next   = 1'b1;
                end
                fuw_pkg::MODE_CLEAR:
                begin
                    res.data = '0;
                    if (clear_ptr_reg < TOTAL)
                    begin
                        res_valid      = 1'b1;
                        emit_addr      = clear_ptr_reg;
                        clear_ptr_next = clear_ptr_reg + CW'(1);
                    end
                end
                fuw_pkg::MODE_DATA:
                begin
                    case (format_reg)
                        fuw_pkg::FMT_FULL_RAW:
                        begin
                            if (write_ptr_reg < TOTAL)
                            begin
                                res_valid      = 1'b1;
                                emit_addr      = write_ptr_reg;
                                write_ptr_next = write_ptr_reg + CW'(1);
                            end
                        end
                        fuw_pkg::FMT_HALF_RAW:
                        begin
                            if (row_cnt_reg < HALF_LIM)
                            begin
                                emit_addr = half_addr;
                                res_valid = (half_addr < TOTAL);
                                if (col_inc >= COL_LIM)
                                begin
                                    col_cnt_next  = '0;
                                    row_cnt_next  = row_cnt_reg + RW'(1);
                                    row_base_next = row_base_reg + PITCH;
                                end
                                else
                                begin
                                    col_cnt_next = col_inc;
                                end
                            end
                        end
                        fuw_pkg::FMT_FULL_DELTA:
                        begin
                            if (row_cnt_reg < ROW_LIM)
                            begin
                                if (awaiting_reg)
                                begin
                                    row_mask_next = item.data;
                                    awaiting_next = 1'b0;
                                end
                                else
                                begin
                                    emit_addr = delta_addr;
                                    res_valid = (delta_addr < TOTAL);
                                end
                                // Mask load or last chunk word: next set chunk or next row
                                if (awaiting_reg || (chunk_word_reg == LAST_WORD))
                                begin
                                    chunk_word_next = '0;
                                    if (seek_found)
                                    begin
                                        chunk_bit_next = seek_idx;
                                    end
                                    else
                                    begin
                                        chunk_bit_next = '0;
                                        row_cnt_next   = row_cnt_reg + RW'(1);
                                        row_base_next  = row_base_reg + PITCH;
                                        awaiting_next  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    chunk_word_next = chunk_word_reg + WW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
        res.address = emit_addr[fuw_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= fuw_pkg::FMT_COPY_LAST;
            write_ptr_reg  <= '0;
            clear_ptr_reg  <= '0;
            row_cnt_reg    <= '0;
            row_base_reg   <= '0;
            col_cnt_reg    <= '0;
            row_mask_reg   <= '0;
            chunk_bit_reg  <= '0;
            chunk_word_reg <= '0;
            awaiting_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                format_reg <= cfg_data;
            end
            if (advance)
            begin
                write_ptr_reg  <= write_ptr_next;
                clear_ptr_reg  <= clear_ptr_next;
                row_cnt_reg    <= row_cnt_next;
                row_base_reg   <= row_base_next;
                col_cnt_reg    <= col_cnt_next;
                row_mask_reg   <= row_mask_next;
                chunk_bit_reg  <= chunk_bit_next;
                chunk_word_reg <= chunk_word_next;
                awaiting_reg   <= awaiting_next;
            end
        end
    end

endmodule

@@ src/fuw_out_stage.sv @@
// Result register of the frame update word writer.
// Depends on fuw_pkg for the result struct.
module fuw_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  fuw_pkg::result_t res,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output fuw_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    fuw_pkg::result_t res_reg;

    // Free when empty or when the held item is taken this cycle
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
